### design/sitda_pkg.sv
// sitda_pkg: shared types and character constants for the signed integer
// to decimal ASCII converter. No dependencies; compile first.
package sitda_pkg;

  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  // Double-dabble steps done in one pipeline stage.
  localparam int DABBLE_STEPS = 8;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam char_t  CHAR_ZERO  = 8'd48;
  localparam char_t  CHAR_MINUS = 8'd45;
  localparam digit_t BCD_ADJ_MIN = 4'd5;
  localparam digit_t BCD_ADJ     = 4'd3;

endpackage

### design/sitda_if.sv
// sitda_if: valid/ready word channels for the converter, input and result.
// Depends on sitda_pkg.
interface sitda_in_if #(parameter int VALUE_BITS = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if ();
  import sitda_pkg::*;
  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

### design/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: signed binary to decimal ASCII text, one
// character per output word. Depends on sitda_pkg and sitda_if.
//
// Usage:
//   in_ch  : one word per integer, field value (VALUE_BITS, two's complement).
//   out_ch : one word per character, text_char plus last_char, which marks
//            the final character of a number. Text is '-' for negatives,
//            then the digits, most significant first, no leading zeros.
//   Output: the first character of a number is registered in the serializer
//            after the negate, dabble and leading digit registers.
//   Throughput: one character per cycle while out_ch.ready is high; a number
//            is 1..11 characters at 32 bits (sign + up to ten digits); the
//            character serializer at the end of the pipe sets the rate.
//   Pipeline: negate -> ceil(VALUE_BITS/8) double-dabble stages (8 bits
//            each) -> leading digit search -> serializer. A new word may
//            enter every cycle while the pipe moves.
//   Stall: when out_ch.ready is low the serializer holds its character and
//            the pipe fills up behind it; nothing is dropped or repeated.
//   Reset: synchronous, active low; clears all valid bits and the
//            serializer. No state is kept between numbers.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sitda_in_if.sink     in_ch,
  sitda_out_if.source  out_ch
);
  import sitda_pkg::*;

  // Digit count of 2^VALUE_BITS, enough for any magnitude.
  localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int NSTG  = (VALUE_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;
  localparam int PAD_W = NSTG * DABBLE_STEPS;
  localparam int BCD_W = NDIG * DIGIT_W;
  localparam int IDX_W = $clog2(NDIG);

  typedef logic [BCD_W-1:0] bcd_t;

  // One double-dabble step: adjust digits >= 5, then shift in a bit.
  function automatic bcd_t dabble_step(input bcd_t bcd, input logic b);
    bcd_t   t;
    digit_t d;
    t = bcd;
    for (int i = 0; i < NDIG; i++) begin
      d = t[i*DIGIT_W +: DIGIT_W];
      if (d >= BCD_ADJ_MIN) begin
        t[i*DIGIT_W +: DIGIT_W] = d + BCD_ADJ;
      end
    end
    return {t[BCD_W-2:0], b};
  endfunction

  // ---------------------------------------------------------------------
  // Stage 0: sign and magnitude. The magnitude of the most negative value
  // fits in VALUE_BITS unsigned bits.
  // ---------------------------------------------------------------------
  logic                  s0_valid_r;
  logic                  s0_neg_r;
  logic [PAD_W-1:0]      s0_mag_r;
  logic                  s0_rdy;
  logic [VALUE_BITS-1:0] mag_nxt;

  // Dabble stages.
  logic             dv_r   [NSTG];
  logic             dneg_r [NSTG];
  logic [PAD_W-1:0] dmag_r [NSTG];
  bcd_t             dbcd_r [NSTG];
  bcd_t             dbcd_nxt [NSTG];
  logic [NSTG-1:0]  d_rdy;

  // Leading digit stage.
  logic             lv_r;
  logic             lneg_r;
  bcd_t             lbcd_r;
  logic [IDX_W-1:0] ltop_r;
  logic [IDX_W-1:0] ltop_nxt;
  logic             l_rdy;

  // Serializer.
  logic             busy_r;
  logic             sign_r;
  logic [IDX_W-1:0] idx_r;
  bcd_t             sbcd_r;
  digit_t           cur_digit;
  logic             out_last;
  logic             out_fire;
  logic             ser_load;

  // Ready chain: a stage moves when it is empty or its successor moves.
  assign out_last = !sign_r && (idx_r == '0);
  assign out_fire = busy_r && out_ch.ready;
  assign ser_load = lv_r && (!busy_r || (out_fire && out_last));
  assign l_rdy    = !lv_r || ser_load;
  assign s0_rdy   = !s0_valid_r || d_rdy[0];
  assign in_ch.ready = s0_rdy;

  assign mag_nxt = in_ch.value[VALUE_BITS-1] ? (~in_ch.value + 1'b1) : in_ch.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_valid_r <= in_ch.valid;
      if (in_ch.valid) begin
        s0_neg_r <= in_ch.value[VALUE_BITS-1];
        s0_mag_r <= PAD_W'(mag_nxt);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Dabble stages: stage k consumes magnitude bits
  // [PAD_W-1-k*8 -: 8], MSB first.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NSTG; k++) begin : g_dab
    logic             up_valid;
    logic             up_neg;
    logic [PAD_W-1:0] up_mag;
    bcd_t             up_bcd;

    if (k == 0) begin : g_first
      assign up_valid = s0_valid_r;
      assign up_neg   = s0_neg_r;
      assign up_mag   = s0_mag_r;
      assign up_bcd   = '0;
    end else begin : g_next
      assign up_valid = dv_r[k-1];
      assign up_neg   = dneg_r[k-1];
      assign up_mag   = dmag_r[k-1];
      assign up_bcd   = dbcd_r[k-1];
    end

    if (k == NSTG - 1) begin : g_rdy_last
      assign d_rdy[k] = !dv_r[k] || l_rdy;
    end else begin : g_rdy_mid
      assign d_rdy[k] = !dv_r[k] || d_rdy[k+1];
    end

    always_comb begin
      bcd_t t;
      t = up_bcd;
      for (int j = 0; j < DABBLE_STEPS; j++) begin
        t = dabble_step(t, up_mag[PAD_W-1-k*DABBLE_STEPS-j]);
      end
      dbcd_nxt[k] = t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (d_rdy[k]) begin
        dv_r[k] <= up_valid;
        if (up_valid) begin
          dneg_r[k] <= up_neg;
          dmag_r[k] <= up_mag;
          dbcd_r[k] <= dbcd_nxt[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Leading digit: index of the highest nonzero digit, zero for value 0.
  // ---------------------------------------------------------------------
  always_comb begin
    ltop_nxt = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (dbcd_r[NSTG-1][i*DIGIT_W +: DIGIT_W] != '0) begin
        ltop_nxt = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else if (l_rdy) begin
      lv_r <= dv_r[NSTG-1];
      if (dv_r[NSTG-1]) begin
        lneg_r <= dneg_r[NSTG-1];
        lbcd_r <= dbcd_r[NSTG-1];
        ltop_r <= ltop_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Serializer: sign first, then digits from ltop down to digit 0.
  // ---------------------------------------------------------------------
  assign cur_digit = sbcd_r[idx_r*DIGIT_W +: DIGIT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
      sign_r <= lneg_r;
      idx_r  <= ltop_r;
      sbcd_r <= lbcd_r;
    end else if (out_fire) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else if (idx_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign out_ch.valid     = busy_r;
  assign out_ch.text_char = sign_r ? CHAR_MINUS : (CHAR_ZERO + char_t'(cur_digit));
  assign out_ch.last_char = out_last;

`ifndef SYNTH
  // The minus sign always has digits after it.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.text_char == CHAR_MINUS) |-> !out_ch.last_char)
    else $error("minus sign flagged as last character");

  // Every character is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.text_char == CHAR_MINUS ||
                      (out_ch.text_char >= CHAR_ZERO &&
                       out_ch.text_char <= CHAR_ZERO + 8'd9)))
    else $error("illegal output character");

  // Digit pointer stays within the BCD word.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= IDX_W'(NDIG - 1)))
    else $error("digit index out of range");

  // Reset empties the serializer, the leading digit stage and stage 0.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> (!busy_r && !lv_r && !s0_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
